// ===== hw/rtl/ohlc_pkg.sv =====
// ----------------------------------------------------------------------------
// ohlc_pkg: shared types and constants of the OHLC bar aggregator
// Beat layouts, candle word, result status codes and default sizes.
// ----------------------------------------------------------------------------
package ohlc_pkg;

    localparam int DEF_STORE_DEPTH = 1024;
    localparam int DEF_MAX_RUN     = 64;

    localparam int TIME_W   = 48;
    localparam int PRICE_W  = 32;
    localparam int LEN_W    = 27;
    localparam int INDEX_W  = 10;
    localparam int STEP_W   = $clog2(TIME_W);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(60000);

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEFORE = 2'd1,
        ST_BEYOND = 2'd2,
        ST_GAP    = 2'd3
    } status_t;

    // One stored candle; open sits in the lowest bits.
    typedef struct packed {
        logic [PRICE_W-1:0] close_px;
        logic [PRICE_W-1:0] low_px;
        logic [PRICE_W-1:0] high_px;
        logic [PRICE_W-1:0] open_px;
    } candle_t;

    typedef struct packed {
        logic [PRICE_W-1:0] tick_close;
        logic [PRICE_W-1:0] tick_low;
        logic [PRICE_W-1:0] tick_high;
        logic [PRICE_W-1:0] tick_open;
        logic [TIME_W-1:0]  tick_time;
    } tick_beat_t;

    typedef struct packed {
        logic [5:0]         pad;
        candle_t            candle;
        logic [TIME_W-1:0]  bar_time;
        logic [INDEX_W-1:0] bar_index;
    } bar_beat_t;

    localparam int S_DATA_W = $bits(tick_beat_t);
    localparam int M_DATA_W = $bits(bar_beat_t);
    localparam int USER_W   = 3;

endpackage

// ===== hw/rtl/ohlc_bar_aggregator.sv =====
// ----------------------------------------------------------------------------
// ohlc_bar_aggregator: price ticks to OHLC candles
// Each tick beat is snapped to its candle, which is updated in a candle store
// held in one synchronous RAM, with flat fillers appended across gaps. The
// bar length comes from the length register written over the cfg channel and
// is captured when a tick is accepted; a length of zero acts as one. Ticks are
// handled one at a time, and a one-bit-per-cycle divider sets the pace. Stalls
// on the result side hold up the tick in progress. The next tick is accepted no
// earlier than the cycle after the final result of the previous one is loaded;
// that result stays in the output register while the next tick is already
// being worked on.
// ----------------------------------------------------------------------------
module ohlc_bar_aggregator #(
    parameter int STORE_DEPTH = ohlc_pkg::DEF_STORE_DEPTH,
    parameter int MAX_RUN     = ohlc_pkg::DEF_MAX_RUN
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ohlc_pkg::LEN_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tick_time, tick_open, tick_high, tick_low, tick_close
    input  logic [ohlc_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bar_index, bar_time, bar_open, bar_high, bar_low, bar_close, zero pad
    output logic [ohlc_pkg::M_DATA_W-1:0] m_tdata,
    // gap_fill, status
    output logic [ohlc_pkg::USER_W-1:0]   m_tuser,
    output logic                          m_tlast
);
    import ohlc_pkg::*;

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int PROD_W = IDX_W + LEN_W;
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(TIME_W - 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DIV    = 12'b0000_0000_0010,
        S_CHECK  = 12'b0000_0000_0100,
        S_FIRST  = 12'b0000_0000_1000,
        S_ERR    = 12'b0000_0001_0000,
        S_CHECK2 = 12'b0000_0010_0000,
        S_MUL    = 12'b0000_0100_0000,
        S_ADD    = 12'b0000_1000_0000,
        S_RDFLAT = 12'b0001_0000_0000,
        S_FILL   = 12'b0010_0000_0000,
        S_RD     = 12'b0100_0000_0000,
        S_UPD    = 12'b1000_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [LEN_W-1:0]     len_cfg_reg, len_cfg_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    tick_beat_t           tick_reg, tick_next;
    logic [TIME_W-1:0]    first_reg, first_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TIME_W-1:0]    dvd_reg, dvd_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 pass_reg, pass_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     s_reg, s_next;
    logic                 fill_reg, fill_next;
    status_t              err_reg, err_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [TIME_W-1:0]    bt_reg, bt_next;

    bar_beat_t            out_reg, out_next;
    logic [USER_W-1:0]    user_reg, user_next;
    logic                 last_reg, last_next;
    logic                 valid_reg, valid_next;

    candle_t              mem [STORE_DEPTH];
    candle_t              rdata_reg;
    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_waddr, mem_raddr;
    candle_t              mem_wdata;

    logic                 out_free;
    logic                 emit;
    logic [IDX_W-1:0]     emit_idx;
    logic [IDX_W+9:0]     emit_idx_ext;
    logic [TIME_W-1:0]    emit_time;
    candle_t              emit_candle;
    logic                 emit_gap;
    status_t              emit_status;
    logic                 emit_last;

    logic [LEN_W:0]       trial;
    logic                 trial_ge;
    logic [LEN_W:0]       trial_diff;
    logic [TIME_W-1:0]    snap;
    logic [IDX_W-1:0]     idx_q;
    logic                 need_fill;
    logic [31:0]          gap_cnt;
    candle_t              flat;
    candle_t              tick_candle;
    candle_t              upd;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    // Restoring divider step: one quotient bit per cycle.
    assign trial      = {rem_reg, dvd_reg[TIME_W-1]};
    assign trial_ge   = trial >= {1'b0, len_reg};
    assign trial_diff = trial - {1'b0, len_reg};

    assign snap      = tick_reg.tick_time - TIME_W'(rem_reg);
    assign idx_q     = dvd_reg[IDX_W-1:0];
    assign need_fill = {1'b0, idx_q} >= count_reg;
    assign gap_cnt   = 32'(idx_q) - 32'(count_reg);

    assign flat = '{close_px: rdata_reg.close_px, low_px: rdata_reg.close_px,
                    high_px: rdata_reg.close_px, open_px: rdata_reg.close_px};
    assign tick_candle = '{close_px: tick_reg.tick_close, low_px: tick_reg.tick_low,
                           high_px: tick_reg.tick_high, open_px: tick_reg.tick_open};

    always_comb begin
        upd          = rdata_reg;
        upd.close_px = tick_reg.tick_open;
        if (tick_reg.tick_low < rdata_reg.low_px) begin
            upd.low_px = tick_reg.tick_low;
        end
        if (tick_reg.tick_high > rdata_reg.high_px) begin
            upd.high_px = tick_reg.tick_high;
        end
    end

    always_comb begin
        state_next   = state_reg;
        len_cfg_next = len_cfg_reg;
        len_next     = len_reg;
        tick_next    = tick_reg;
        first_next   = first_reg;
        count_next   = count_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        pass_next    = pass_reg;
        idx_next     = idx_reg;
        s_next       = s_reg;
        fill_next    = fill_reg;
        err_next     = err_reg;
        prod_next    = prod_reg;
        bt_next      = bt_reg;

        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = '0;
        mem_raddr   = '0;
        mem_wdata   = '0;

        emit        = 1'b0;
        emit_idx    = '0;
        emit_time   = '0;
        emit_candle = '0;
        emit_gap    = 1'b0;
        emit_status = ST_OK;
        emit_last   = 1'b0;

        if (cfg_valid) begin
            len_cfg_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    tick_next  = tick_beat_t'(s_tdata);
                    len_next   = (len_cfg_reg == '0) ? LEN_W'(1) : len_cfg_reg;
                    dvd_next   = tick_next.tick_time;
                    rem_next   = '0;
                    step_next  = '0;
                    pass_next  = 1'b0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                dvd_next  = {dvd_reg[TIME_W-2:0], trial_ge};
                rem_next  = trial_ge ? trial_diff[LEN_W-1:0] : trial[LEN_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == DIV_LAST) begin
                    state_next = pass_reg ? S_CHECK2 : S_CHECK;
                end
            end
            S_CHECK: begin
                if (count_reg == '0) begin
                    first_next = snap;
                    state_next = S_FIRST;
                end else if (snap < first_reg) begin
                    err_next   = ST_BEFORE;
                    state_next = S_ERR;
                end else begin
                    dvd_next   = snap - first_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    pass_next  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_FIRST: begin
                if (out_free) begin
                    mem_we      = 1'b1;
                    mem_wdata   = tick_candle;
                    count_next  = CNT_W'(1);
                    emit        = 1'b1;
                    emit_time   = first_reg;
                    emit_candle = tick_candle;
                    emit_last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = err_reg;
                    emit_last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_CHECK2: begin
                idx_next = idx_q;
                if (dvd_reg >= TIME_W'(STORE_DEPTH)) begin
                    err_next   = ST_BEYOND;
                    state_next = S_ERR;
                end else if (need_fill) begin
                    if (gap_cnt >= 32'(MAX_RUN - 1)) begin
                        err_next   = ST_GAP;
                        state_next = S_ERR;
                    end else begin
                        fill_next  = 1'b1;
                        s_next     = count_reg[IDX_W-1:0];
                        count_next = CNT_W'({1'b0, idx_q}) + CNT_W'(1);
                        state_next = S_MUL;
                    end
                end else begin
                    fill_next  = 1'b0;
                    s_next     = idx_q;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = PROD_W'(s_reg) * PROD_W'(len_reg);
                state_next = S_ADD;
            end
            S_ADD: begin
                bt_next    = first_reg + TIME_W'(prod_reg);
                state_next = fill_reg ? S_RDFLAT : S_RD;
            end
            S_RDFLAT: begin
                // Fillers copy the close of the last stored candle.
                mem_re     = 1'b1;
                mem_raddr  = s_reg - IDX_W'(1);
                state_next = S_FILL;
            end
            S_FILL: begin
                if (out_free) begin
                    mem_we      = 1'b1;
                    mem_waddr   = s_reg;
                    mem_wdata   = flat;
                    emit        = 1'b1;
                    emit_idx    = s_reg;
                    emit_time   = bt_reg;
                    emit_candle = flat;
                    emit_gap    = 1'b1;
                    if (s_reg == idx_reg) begin
                        state_next = S_RD;
                    end else begin
                        s_next  = s_reg + IDX_W'(1);
                        bt_next = bt_reg + TIME_W'(len_reg);
                    end
                end
            end
            S_RD: begin
                // The last filler was written the cycle before, so this read sees it.
                mem_re     = 1'b1;
                mem_raddr  = idx_reg;
                state_next = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    mem_we      = 1'b1;
                    mem_waddr   = idx_reg;
                    mem_wdata   = upd;
                    emit        = 1'b1;
                    emit_idx    = idx_reg;
                    emit_time   = bt_reg;
                    emit_candle = upd;
                    emit_last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign emit_idx_ext = {10'b0, emit_idx};

    always_comb begin
        out_next   = out_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        valid_next = valid_reg;
        if (emit) begin
            out_next.pad       = '0;
            out_next.candle    = emit_candle;
            out_next.bar_time  = emit_time;
            out_next.bar_index = emit_idx_ext[INDEX_W-1:0];
            user_next          = {emit_status, emit_gap};
            last_next          = emit_last;
            valid_next         = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_cfg_reg <= LEN_RESET;
            first_reg   <= '0;
            count_reg   <= '0;
            valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_cfg_reg <= len_cfg_next;
            first_reg   <= first_next;
            count_reg   <= count_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        tick_reg <= tick_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        pass_reg <= pass_next;
        idx_reg  <= idx_next;
        s_reg    <= s_next;
        fill_reg <= fill_next;
        err_reg  <= err_next;
        prod_reg <= prod_next;
        bt_reg   <= bt_next;
        out_reg  <= out_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

// ===== hw/rtl/ohlc_checker.sv =====
// ----------------------------------------------------------------------------
// ohlc_checker: port-level checks for the OHLC bar aggregator
// Watches the result stream of the aggregator and is bound to its top level.
// ----------------------------------------------------------------------------
module ohlc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ohlc_pkg::M_DATA_W-1:0] m_tdata,
    input logic [ohlc_pkg::USER_W-1:0]   m_tuser,
    input logic                          m_tlast
);
    import ohlc_pkg::*;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // An error result is a single, all-zero beat that ends its run.
    a_error_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:1] != ST_OK |-> m_tlast && m_tdata == '0 && !m_tuser[0])
        else $error("malformed error beat");

    a_fill_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tlast && m_tuser[2:1] == ST_OK)
        else $error("gap filler beat ends a run or carries an error");

    // While a run is still being delivered, no new tick may be taken.
    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("tick accepted in the middle of a run");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result beat changed");

endmodule

bind ohlc_bar_aggregator ohlc_checker u_ohlc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the OHLC bar aggregator
// Price ticks go in as stream beats and candle beats come back out. A
// candle-store model inside the bench predicts every candle beat, and each
// beat is checked field by field as it arrives. A directed opening covers
// price extremes, gap filling, older-bar updates, every reject status and
// bar length changes; random phases under several bar lengths follow.
// Both stream sides idle and stall at random throughout.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ohlc_pkg::*;

    localparam int STORE_DEPTH = DEF_STORE_DEPTH;
    localparam int MAX_RUN     = DEF_MAX_RUN;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(86400000);

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [TIME_W-1:0]  start;
        candle_t            prices;
        logic               gap_fill;
        status_t            status;
        logic               last;
    } bar_result_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LEN_W-1:0]    cfg_data  = LEN_RESET;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    // tick_time, tick_open, tick_high, tick_low, tick_close
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    // bar_index, bar_time, bar_open, bar_high, bar_low, bar_close, zero pad
    logic [M_DATA_W-1:0] m_tdata;
    // gap_fill, status
    logic [USER_W-1:0]   m_tuser;
    logic                m_tlast;

    // Candle store model and its bookkeeping.
    candle_t            candle_store [STORE_DEPTH];
    logic [TIME_W-1:0]  first_bar = '0;
    int unsigned        bars_held = 0;
    logic [LEN_W-1:0]   bar_len   = LEN_RESET;
    bar_result_t        pending_bars [$];

    int mismatches  = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int ready_mode  = 0;
    int mode_cycles = 0;

    ohlc_bar_aggregator #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_RUN     (MAX_RUN)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAIL ohlc_bar_aggregator");
        $finish;
    end

    function automatic logic [63:0] eff_len();
        return (bar_len == '0) ? 64'd1 : 64'(bar_len);
    endfunction

    function automatic void expect_bar(logic [63:0] idx, logic gap, logic last);
        bar_result_t r;
        logic [63:0] start;
        start      = 64'(first_bar) + idx * eff_len();
        r.index    = idx[INDEX_W-1:0];
        r.start    = start[TIME_W-1:0];
        r.prices   = candle_store[idx];
        r.gap_fill = gap;
        r.status   = ST_OK;
        r.last     = last;
        pending_bars.push_back(r);
    endfunction

    function automatic void expect_reject(status_t code);
        bar_result_t r;
        r.index    = '0;
        r.start    = '0;
        r.prices   = '0;
        r.gap_fill = 1'b0;
        r.status   = code;
        r.last     = 1'b1;
        pending_bars.push_back(r);
    endfunction

    // Applies one accepted tick to the store model and queues its candles.
    function automatic void fold_tick(tick_beat_t tk);
        logic [63:0]        len;
        logic [63:0]        t;
        logic [63:0]        snap;
        logic [63:0]        idx;
        logic [PRICE_W-1:0] flat;
        logic [63:0]        s;
        len  = eff_len();
        t    = 64'(tk.tick_time);
        snap = t - (t % len);
        if (bars_held == 0) begin
            candle_store[0].open_px  = tk.tick_open;
            candle_store[0].high_px  = tk.tick_high;
            candle_store[0].low_px   = tk.tick_low;
            candle_store[0].close_px = tk.tick_close;
            first_bar = snap[TIME_W-1:0];
            bars_held = 1;
            expect_bar(64'd0, 1'b0, 1'b1);
            return;
        end
        if (snap < 64'(first_bar)) begin
            expect_reject(ST_BEFORE);
            return;
        end
        idx = (snap - 64'(first_bar)) / len;
        if (idx >= 64'(STORE_DEPTH)) begin
            expect_reject(ST_BEYOND);
            return;
        end
        if (idx >= 64'(bars_held)) begin
            if (idx - 64'(bars_held) + 1 > 64'(MAX_RUN - 1)) begin
                expect_reject(ST_GAP);
                return;
            end
            flat = candle_store[bars_held - 1].close_px;
            for (s = 64'(bars_held); s <= idx; s++) begin
                candle_store[s] = {4{flat}};
                expect_bar(s, 1'b1, 1'b0);
            end
            bars_held = 32'(idx) + 1;
        end
        if (tk.tick_low < candle_store[idx].low_px)
            candle_store[idx].low_px = tk.tick_low;
        if (tk.tick_high > candle_store[idx].high_px)
            candle_store[idx].high_px = tk.tick_high;
        candle_store[idx].close_px = tk.tick_open;
        expect_bar(idx, 1'b0, 1'b1);
    endfunction

    function automatic tick_beat_t make_tick(logic [TIME_W-1:0] t, logic [PRICE_W-1:0] o,
                                             logic [PRICE_W-1:0] h, logic [PRICE_W-1:0] l,
                                             logic [PRICE_W-1:0] c);
        tick_beat_t tk;
        tk.tick_time  = t;
        tk.tick_open  = o;
        tk.tick_high  = h;
        tk.tick_low   = l;
        tk.tick_close = c;
        return tk;
    endfunction

    // A time somewhere inside the given candle under the current bar length.
    function automatic logic [TIME_W-1:0] near_bar_time(logic [63:0] idx);
        logic [63:0] len;
        logic [63:0] t;
        len = eff_len();
        t   = 64'(first_bar) + idx * len + 64'($urandom_range(0, 32'(len - 1)));
        return t[TIME_W-1:0];
    endfunction

    function automatic tick_beat_t random_tick();
        int unsigned       pick;
        int unsigned       back;
        logic [63:0]       idx;
        logic [TIME_W-1:0] t;
        pick = $urandom_range(0, 99);
        back = $urandom_range(0, 3);
        if (back >= bars_held)
            back = bars_held - 1;
        if (pick < 50)
            t = near_bar_time(64'(bars_held - 1 - back));
        else if (pick < 78)
            t = near_bar_time(64'(bars_held + $urandom_range(0, 4)));
        else if (pick < 84)
            t = near_bar_time(64'(bars_held + $urandom_range(5, MAX_RUN - 2)));
        else if (pick < 89)
            t = near_bar_time(64'(bars_held + $urandom_range(MAX_RUN - 1, MAX_RUN + 200)));
        else if (pick < 94)
            t = first_bar - TIME_W'(1) - TIME_W'($urandom_range(0, 1000000));
        else
            t = TIME_W'({$urandom, $urandom});
        return make_tick(t, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Sends one tick beat; tvalid stays high into the next call inside a burst.
    task automatic send_tick(tick_beat_t tk);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            case ($urandom_range(0, 9))
                0, 1, 2:    gap = 0;
                3, 4, 5, 6: gap = $urandom_range(1, 8);
                default:    gap = $urandom_range(9, 160);
            endcase
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tk;
        do @(posedge aclk); while (!s_tready);
        fold_tick(tk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_bars.size() != 0)
            @(posedge aclk);
    endtask

    // Never called twice in a row, so cfg_valid is not dropped and raised in one step.
    task automatic set_bar_length(logic [LEN_W-1:0] len);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bar_len = len;
    endtask

    task automatic test_first_tick();
        send_tick(make_tick(48'h7A5C_3E91_2B47, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
    endtask

    task automatic test_gap_fill();
        // Same candle with extremes that must not move high or low.
        send_tick(make_tick(near_bar_time(0), 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 32'h0));
        // Next candle: one filler, then the same slot again after the update.
        send_tick(make_tick(near_bar_time(1), 32'h8000_0001, 32'hFFFF_FFFF, 32'h0, 32'h5A5A_5A5A));
        send_tick(make_tick(near_bar_time(4), $urandom, $urandom, $urandom, $urandom));
        send_tick(make_tick(near_bar_time(2), $urandom, $urandom, $urandom, $urandom));
        // Longest allowed run of fillers, then one past it.
        send_tick(make_tick(near_bar_time(64'(bars_held + MAX_RUN - 2)),
                            $urandom, $urandom, $urandom, $urandom));
        send_tick(make_tick(near_bar_time(64'(bars_held + MAX_RUN - 1)),
                            $urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic test_rejects();
        send_tick(make_tick('0, $urandom, $urandom, $urandom, $urandom));
        send_tick(make_tick('1, $urandom, $urandom, $urandom, $urandom));
        send_tick(make_tick(near_bar_time(STORE_DEPTH), $urandom, $urandom, $urandom, $urandom));
        send_tick(make_tick(near_bar_time(STORE_DEPTH - 1),
                            $urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic test_bar_length();
        set_bar_length(LEN_W'(1));
        send_tick(make_tick(near_bar_time(64'(bars_held)), $urandom, $urandom, $urandom, $urandom));
        send_tick(make_tick(first_bar - TIME_W'(1), $urandom, $urandom, $urandom, $urandom));
        // A zero length behaves as one millisecond.
        set_bar_length('0);
        send_tick(make_tick(near_bar_time(64'(bars_held + 1)),
                            $urandom, $urandom, $urandom, $urandom));
        set_bar_length(LEN_MAX);
        send_tick(make_tick(near_bar_time(0), $urandom, $urandom, $urandom, $urandom));
        send_tick(make_tick(near_bar_time(64'(bars_held + 2)),
                            $urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic test_random_ticks();
        int               phase;
        logic [LEN_W-1:0] len;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       len = LEN_W'($urandom_range(1, 1000));
                1:       len = LEN_RESET;
                2:       len = LEN_W'($urandom_range(1001, 86400000));
                default: len = ($urandom_range(0, 1) == 0) ? LEN_W'(1) : '0;
            endcase
            set_bar_length(len);
            repeat (41) send_tick(random_tick());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_first_tick();
        test_gap_fill();
        test_rejects();
        test_bar_length();
        test_random_ticks();
        wait_drained();
        repeat (200) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS ohlc_bar_aggregator");
        else
            $display("FAIL ohlc_bar_aggregator");
        $finish;
    end

    // Result side: stretches of steady ready, random ready and long stalls.
    always @(posedge aclk) begin
        if (mode_cycles == 0) begin
            mode_cycles = $urandom_range(20, 200);
            ready_mode  = $urandom_range(0, 2);
        end
        mode_cycles--;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(1, 30);
                        m_tready <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : check_bars
        bar_beat_t   beat;
        bar_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beat = m_tdata;
            if (pending_bars.size() == 0) begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t ns: candle beat with nothing expected, expected none, got index %0h",
                             $time, beat.bar_index);
            end else begin
                want = pending_bars.pop_front();
                compare_field("bar_index", 64'(want.index), 64'(beat.bar_index));
                compare_field("bar_time", 64'(want.start), 64'(beat.bar_time));
                compare_field("bar_open", 64'(want.prices.open_px), 64'(beat.candle.open_px));
                compare_field("bar_high", 64'(want.prices.high_px), 64'(beat.candle.high_px));
                compare_field("bar_low", 64'(want.prices.low_px), 64'(beat.candle.low_px));
                compare_field("bar_close", 64'(want.prices.close_px), 64'(beat.candle.close_px));
                compare_field("tdata pad", 64'd0, 64'(beat.pad));
                compare_field("gap_fill", 64'(want.gap_fill), 64'(m_tuser[0]));
                compare_field("status", 64'(want.status), 64'(m_tuser[2:1]));
                compare_field("last_of_run", 64'(want.last), 64'(m_tlast));
            end
        end
    end

endmodule
